// ----- rtl/core/stcs_pkg.sv -----
// ----------------------------------------------------------------------------
// stcs_pkg: shared constants and types of the strain to coulomb stress core
// Field widths, fixed-point scalings, register indexes, saturation and magnitude helpers.
// ----------------------------------------------------------------------------
package stcs_pkg;

	// fraction bits of the incoming strains (24..40)
	localparam int STRAIN_FRAC_BITS = 36;

	localparam int STRAIN_W  = 32;
	localparam int PRES_W    = 40;
	localparam int MOD_W     = 40;
	localparam int COEF_W    = 17;
	localparam int NORM_W    = 18;
	localparam int OUT_W     = 42;
	localparam int CFG_W     = 40;
	localparam int CFG_IDX_W = 3;

	// Q0.16 / Q1.16 fraction and its rounding constant
	localparam int Q_FRAC  = 16;
	localparam int ROUND16 = 1 << (Q_FRAC - 1);

	// hooke stage
	localparam int MOD_LO_W  = 20;
	localparam int MOD_HI_W  = MOD_W - MOD_LO_W;
	localparam int ESUM_W    = STRAIN_W + 2;
	localparam int ACC_W     = STRAIN_FRAC_BITS + 56;
	localparam int SAT_IN_W  = ACC_W - STRAIN_FRAC_BITS;

	// plane stage
	localparam int TQ_W    = OUT_W + NORM_W + 2;
	localparam int TRAC_W  = TQ_W - Q_FRAC;
	localparam int TN_W    = TRAC_W + NORM_W;
	localparam int SN_W    = TN_W - Q_FRAC;
	localparam int HALF_W  = SN_W / 2;
	localparam int SQ_W    = 2 * SN_W;
	localparam int TAU2_W  = SQ_W + 2;
	localparam int RAD_W   = 90;
	localparam int ROOT_W  = 45;
	localparam int FRP_W   = COEF_W + SN_W;
	localparam int FR_W    = FRP_W - Q_FRAC;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LAMBDA   = 3'd0,
		REG_SHEAR    = 3'd1,
		REG_BIOT     = 3'd2,
		REG_FRICTION = 3'd3,
		REG_NORMAL_X = 3'd4,
		REG_NORMAL_Y = 3'd5,
		REG_NORMAL_Z = 3'd6
	} cfg_reg_t;

	typedef logic signed [OUT_W-1:0] stress_t;

	// clamp to the signed output range
	function automatic stress_t sat_out(input logic signed [SAT_IN_W-1:0] x);
		logic [SAT_IN_W-OUT_W:0] top;
		top = x[SAT_IN_W-1:OUT_W-1];
		if (top == '0 || top == '1) begin
			sat_out = x[OUT_W-1:0];
		end else if (x[SAT_IN_W-1]) begin
			sat_out = {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			sat_out = {1'b0, {(OUT_W-1){1'b1}}};
		end
	endfunction

	// magnitude of a signed word, exact for the most negative value
	function automatic logic [SN_W-1:0] mag_sn(input logic signed [SN_W-1:0] x);
		mag_sn = x[SN_W-1] ? SN_W'(-x) : SN_W'(x);
	endfunction

endpackage

// ----- rtl/core/strain_to_coulomb_stress_core.sv -----
// ----------------------------------------------------------------------------
// strain_to_coulomb_stress_core: hooke stresses and coulomb failure stress
// Isotropic Hooke's law with Biot pore-pressure term, traction on a receiver
// plane, shear magnitude by pipelined square root, and CFS per cell.
// ----------------------------------------------------------------------------
// Usage:
// - input channel: in_valid / in_stall with six strains and a pore pressure;
//   a transaction moves one cell. output channel: out_valid / out_stall with
//   six stresses and failure_stress, one result transaction per cell.
// - configuration: cfg_we, cfg_index, cfg_data; writes land at the clock edge.
//   the user must write only while the core is idle; the core does not enforce
//   it. indexes above six are ignored. throughput: one cell per clock while the
//   skid is empty; every stage advances together.
// - pipeline: s1 loads at the accepting edge, then s2..s57 (10 more arithmetic
//   stages, 45 square-root stages of one root bit each, one saturation stage)
//   follow, and the output register comes last.
// - stall: the output register is backed by a one-entry skid buffer; while
//   the skid is empty the pipeline keeps running and input is accepted. once
//   the skid fills, in_stall rises and the whole pipeline freezes until the
//   receiver drains a result.
// - reset: arst_n clears all valid bits, including those of the skid and the
//   output register, and loads the register defaults (friction 0.4, normal +z).
// ----------------------------------------------------------------------------
module strain_to_coulomb_stress_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_we,
	input  logic [stcs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [stcs_pkg::CFG_W-1:0]           cfg_data,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [stcs_pkg::STRAIN_W-1:0] strain_xx,
	input  logic signed [stcs_pkg::STRAIN_W-1:0] strain_yy,
	input  logic signed [stcs_pkg::STRAIN_W-1:0] strain_zz,
	input  logic signed [stcs_pkg::STRAIN_W-1:0] strain_xy,
	input  logic signed [stcs_pkg::STRAIN_W-1:0] strain_xz,
	input  logic signed [stcs_pkg::STRAIN_W-1:0] strain_yz,
	input  logic signed [stcs_pkg::PRES_W-1:0]   pore_pressure,
	// output channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [stcs_pkg::OUT_W-1:0]    stress_xx,
	output logic signed [stcs_pkg::OUT_W-1:0]    stress_yy,
	output logic signed [stcs_pkg::OUT_W-1:0]    stress_zz,
	output logic signed [stcs_pkg::OUT_W-1:0]    stress_xy,
	output logic signed [stcs_pkg::OUT_W-1:0]    stress_xz,
	output logic signed [stcs_pkg::OUT_W-1:0]    stress_yz,
	output logic signed [stcs_pkg::OUT_W-1:0]    failure_stress
);
	import stcs_pkg::*;

	// stage numbering: s1..s11 arithmetic, s12..s56 square root, s57 cfs
	localparam int LAST_STAGE = 12 + ROOT_W;
	localparam int ST_DLY     = LAST_STAGE - 4;
	localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) <<< (STRAIN_FRAC_BITS - 1);

	// ---------------- configuration registers ----------------
	logic        [MOD_W-1:0]  lam_q, mu_q;
	logic        [COEF_W-1:0] biot_q, fric_q;
	logic signed [NORM_W-1:0] nx_q, ny_q, nz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lam_q  <= '0;
			mu_q   <= '0;
			biot_q <= '0;
			fric_q <= COEF_W'(26214);
			nx_q   <= '0;
			ny_q   <= '0;
			nz_q   <= NORM_W'(65536);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LAMBDA:   lam_q  <= cfg_data[MOD_W-1:0];
				REG_SHEAR:    mu_q   <= cfg_data[MOD_W-1:0];
				REG_BIOT:     biot_q <= cfg_data[COEF_W-1:0];
				REG_FRICTION: fric_q <= cfg_data[COEF_W-1:0];
				REG_NORMAL_X: nx_q   <= $signed(cfg_data[NORM_W-1:0]);
				REG_NORMAL_Y: ny_q   <= $signed(cfg_data[NORM_W-1:0]);
				REG_NORMAL_Z: nz_q   <= $signed(cfg_data[NORM_W-1:0]);
				default: ;
			endcase
		end
	end

	// ---------------- flow control ----------------
	// the pipeline moves as one; it only freezes once the skid holds a result
	logic en, accept, out_fire;
	logic out_v_q, skid_v_q;

	assign en       = !skid_v_q;
	assign in_stall = skid_v_q;
	assign accept   = in_valid && !in_stall;
	assign out_fire = out_v_q && !out_stall;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s57;
	logic v_sq [ROOT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s57 <= 1'b0;
		end else if (en) begin
			v_s1  <= accept;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s57 <= v_sq[ROOT_W-1];
		end
	end

	// ---------------- s1: capture strains, volumetric sum ----------------
	logic signed [STRAIN_W-1:0] e_s1 [6];
	logic signed [ESUM_W-1:0]   esum_s1;
	logic signed [PRES_W-1:0]   p_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			e_s1[0] <= strain_xx;
			e_s1[1] <= strain_yy;
			e_s1[2] <= strain_zz;
			e_s1[3] <= strain_xy;
			e_s1[4] <= strain_xz;
			e_s1[5] <= strain_yz;
			esum_s1 <= ESUM_W'(strain_xx) + ESUM_W'(strain_yy) + ESUM_W'(strain_zz);
			p_s1    <= pore_pressure;
		end
	end

	// ---------------- s2: modulus partial products ----------------
	// moduli split into low and high halves to keep each multiplier narrow
	logic signed [MOD_LO_W+STRAIN_W:0] mulo_s2 [6];
	logic signed [MOD_HI_W+STRAIN_W:0] muhi_s2 [6];
	logic signed [MOD_LO_W+ESUM_W:0]   lamlo_s2;
	logic signed [MOD_HI_W+ESUM_W:0]   lamhi_s2;
	logic signed [COEF_W+PRES_W:0]     bp_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 6; i++) begin
				mulo_s2[i] <= $signed({1'b0, mu_q[MOD_LO_W-1:0]}) * e_s1[i];
				muhi_s2[i] <= $signed({1'b0, mu_q[MOD_W-1:MOD_LO_W]}) * e_s1[i];
			end
			lamlo_s2 <= $signed({1'b0, lam_q[MOD_LO_W-1:0]}) * esum_s1;
			lamhi_s2 <= $signed({1'b0, lam_q[MOD_W-1:MOD_LO_W]}) * esum_s1;
			bp_s2    <= $signed({1'b0, biot_q}) * p_s1;
		end
	end

	// ---------------- s3: 2*mu*e and the shared normal term ----------------
	logic signed [ACC_W-1:0] mu2e_c [6];
	logic signed [ACC_W-1:0] com_c;
	logic signed [ACC_W-1:0] mu2e_s3 [6];
	logic signed [ACC_W-1:0] com_s3;

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			mu2e_c[i] = ((ACC_W'(muhi_s2[i]) <<< MOD_LO_W) + ACC_W'(mulo_s2[i])) <<< 1;
		end
		// lambda*trace - alpha*p, rounding half folded in
		com_c = (ACC_W'(lamhi_s2) <<< MOD_LO_W) + ACC_W'(lamlo_s2)
		      - (ACC_W'(bp_s2) <<< (STRAIN_FRAC_BITS - Q_FRAC)) + HALF_LSB;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mu2e_s3 <= mu2e_c;
			com_s3  <= com_c;
		end
	end

	// ---------------- s4: add, scale and saturate the stresses ----------------
	logic signed [ACC_W-1:0] acc_c [6];
	stress_t                 st_s4 [6];

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			acc_c[i] = mu2e_s3[i] + ((i < 3) ? com_s3 : HALF_LSB);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 6; i++) begin
				st_s4[i] <= sat_out(acc_c[i][ACC_W-1:STRAIN_FRAC_BITS]);
			end
		end
	end

	// stresses ride a delay line from s5 up to s57
	stress_t st_line_s5 [ST_DLY][6];

	always_ff @(posedge clk) begin
		if (en) begin
			st_line_s5[0] <= st_s4;
			for (int j = 1; j < ST_DLY; j++) begin
				st_line_s5[j] <= st_line_s5[j-1];
			end
		end
	end

	// ---------------- s5: stress times normal ----------------
	// order xx,xy,xz / xy,yy,yz / xz,yz,zz
	logic signed [OUT_W+NORM_W-1:0] tqp_s5 [9];

	always_ff @(posedge clk) begin
		if (en) begin
			tqp_s5[0] <= st_s4[0] * nx_q;
			tqp_s5[1] <= st_s4[3] * ny_q;
			tqp_s5[2] <= st_s4[4] * nz_q;
			tqp_s5[3] <= st_s4[3] * nx_q;
			tqp_s5[4] <= st_s4[1] * ny_q;
			tqp_s5[5] <= st_s4[5] * nz_q;
			tqp_s5[6] <= st_s4[4] * nx_q;
			tqp_s5[7] <= st_s4[5] * ny_q;
			tqp_s5[8] <= st_s4[2] * nz_q;
		end
	end

	// ---------------- s6: traction, rounded ----------------
	logic signed [TQ_W-1:0]   tq_c [3];
	logic signed [TRAC_W-1:0] t_s6 [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			tq_c[r] = TQ_W'(tqp_s5[3*r]) + TQ_W'(tqp_s5[3*r+1]) + TQ_W'(tqp_s5[3*r+2])
			        + TQ_W'(ROUND16);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				t_s6[r] <= $signed(tq_c[r][TQ_W-1:Q_FRAC]);
			end
		end
	end

	// ---------------- s7: traction times normal ----------------
	logic signed [TN_W-1:0]   tnp_s7 [3];
	logic signed [TRAC_W-1:0] t_s7 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			tnp_s7[0] <= t_s6[0] * nx_q;
			tnp_s7[1] <= t_s6[1] * ny_q;
			tnp_s7[2] <= t_s6[2] * nz_q;
			t_s7      <= t_s6;
		end
	end

	// ---------------- s8: normal stress, wraps at the product width ----------------
	logic        [TN_W-1:0]   sn_c;
	logic signed [SN_W-1:0]   sn_s8;
	logic signed [TRAC_W-1:0] t_s8 [3];

	assign sn_c = tnp_s7[0] + tnp_s7[1] + tnp_s7[2] + TN_W'(ROUND16);

	always_ff @(posedge clk) begin
		if (en) begin
			sn_s8 <= $signed(sn_c[TN_W-1:Q_FRAC]);
			t_s8  <= t_s7;
		end
	end

	// ---------------- s9: square partial products, friction product ----------------
	// slot 0..2 traction, slot 3 normal stress
	logic [SN_W-1:0]     mg_c [4];
	logic [2*HALF_W-1:0] hh_s9 [4], hl_s9 [4], ll_s9 [4];
	logic [FRP_W-1:0]    frp_s9;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			mg_c[r] = mag_sn(SN_W'(t_s8[r]));
		end
		mg_c[3] = mag_sn(sn_s8);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int v = 0; v < 4; v++) begin
				hh_s9[v] <= mg_c[v][SN_W-1:HALF_W] * mg_c[v][SN_W-1:HALF_W];
				hl_s9[v] <= mg_c[v][SN_W-1:HALF_W] * mg_c[v][HALF_W-1:0];
				ll_s9[v] <= mg_c[v][HALF_W-1:0] * mg_c[v][HALF_W-1:0];
			end
			frp_s9 <= fric_q * mg_c[3];
		end
	end

	// ---------------- s10: full squares, rounded friction term ----------------
	logic [SQ_W-1:0]  sq_s10 [4];
	logic [FRP_W-1:0] frs_c;
	logic [FR_W-1:0]  fr_s10;

	assign frs_c = frp_s9 + FRP_W'(ROUND16);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int v = 0; v < 4; v++) begin
				sq_s10[v] <= (SQ_W'(hh_s9[v]) << (2 * HALF_W))
				           + (SQ_W'(hl_s9[v]) << (HALF_W + 1)) + SQ_W'(ll_s9[v]);
			end
			fr_s10 <= frs_c[FRP_W-1:Q_FRAC];
		end
	end

	// ---------------- s11: radicand, clamped at zero ----------------
	logic [TAU2_W-1:0] tau2_c;
	logic [RAD_W-1:0]  rad_s11;
	logic [FR_W-1:0]   fr_s11;

	assign tau2_c = TAU2_W'(sq_s10[0]) + TAU2_W'(sq_s10[1]) + TAU2_W'(sq_s10[2])
	              - TAU2_W'(sq_s10[3]);

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s11 <= tau2_c[TAU2_W-1] ? '0 : tau2_c[RAD_W-1:0];
			fr_s11  <= fr_s10;
		end
	end

	// ---------------- s12..s56: restoring square root, one bit per stage ----------------
	// element k of each array belongs to stage 12+k and settles root bit ROOT_W-1-k
	logic [RAD_W-1:0]  rem_s12  [ROOT_W];
	logic [ROOT_W-1:0] root_s12 [ROOT_W];
	logic [FR_W-1:0]   fr_s12   [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
		localparam int B = ROOT_W - 1 - k;
		logic [RAD_W-1:0]  rem_in, trial;
		logic [ROOT_W-1:0] root_in;
		logic [FR_W-1:0]   fr_in;
		logic              v_in;

		if (k == 0) begin : g_first
			assign rem_in  = rad_s11;
			assign root_in = '0;
			assign fr_in   = fr_s11;
			assign v_in    = v_s11;
		end else begin : g_next
			assign rem_in  = rem_s12[k-1];
			assign root_in = root_s12[k-1];
			assign fr_in   = fr_s12[k-1];
			assign v_in    = v_sq[k-1];
		end

		// (r + 2^b)^2 - r^2 with r holding only the bits above b
		assign trial = (RAD_W'(root_in) << (B + 1)) + (RAD_W'(1) << (2 * B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sq[k] <= 1'b0;
			end else if (en) begin
				v_sq[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					rem_s12[k]  <= rem_in - trial;
					root_s12[k] <= root_in | (ROOT_W'(1) << B);
				end else begin
					rem_s12[k]  <= rem_in;
					root_s12[k] <= root_in;
				end
				fr_s12[k] <= fr_in;
			end
		end
	end

	// ---------------- s57: failure stress ----------------
	stress_t cfs_s57;

	always_ff @(posedge clk) begin
		if (en) begin
			cfs_s57 <= sat_out(SAT_IN_W'(root_s12[ROOT_W-1]) - SAT_IN_W'(fr_s12[ROOT_W-1]));
		end
	end

	// ---------------- output register and skid ----------------
	stress_t out_st_q [6], skid_st_q [6];
	stress_t out_cfs_q, skid_cfs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			// pipeline frozen; skid refills the output on a transaction
			if (out_fire) begin
				skid_v_q <= 1'b0;
			end
		end else if (v_s57) begin
			if (out_v_q && !out_fire) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_fire) begin
				out_st_q  <= skid_st_q;
				out_cfs_q <= skid_cfs_q;
			end
		end else if (v_s57) begin
			if (out_v_q && !out_fire) begin
				skid_st_q  <= st_line_s5[ST_DLY-1];
				skid_cfs_q <= cfs_s57;
			end else begin
				out_st_q  <= st_line_s5[ST_DLY-1];
				out_cfs_q <= cfs_s57;
			end
		end
	end

	assign out_valid      = out_v_q;
	assign stress_xx      = out_st_q[0];
	assign stress_yy      = out_st_q[1];
	assign stress_zz      = out_st_q[2];
	assign stress_xy      = out_st_q[3];
	assign stress_xz      = out_st_q[4];
	assign stress_yz      = out_st_q[5];
	assign failure_stress = out_cfs_q;

	// ---------------- assertions ----------------
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds a result while the output register is empty");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && !out_stall |=> !skid_v_q)
		else $error("skid not drained after an output transaction");

	a_skid_catches: assert property (@(posedge clk) disable iff (!arst_n)
		v_s57 && out_v_q && out_stall && !skid_v_q |=> skid_v_q && out_v_q)
		else $error("result leaving the pipeline was not caught by the skid");

	a_sqrt_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		v_sq[ROOT_W-1] |-> rem_s12[ROOT_W-1] <= RAD_W'({root_s12[ROOT_W-1], 1'b0}))
		else $error("square root remainder exceeds twice the root");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for strain_to_coulomb_stress_core
// Streams strain cells under several register settings and idle patterns,
// predicts stresses and failure stress per cell, and checks every result.
// ----------------------------------------------------------------------------
module tb;
	import stcs_pkg::*;

	// index with no register behind it, writes must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int FB = STRAIN_FRAC_BITS;
	localparam int DRAIN_CYCLES = 70;

	typedef struct {
		logic signed [STRAIN_W-1:0] e[6];
		logic signed [PRES_W-1:0]   pres;
	} cell_t;

	typedef struct {
		stress_t v[7];
	} stress_set_t;

	// ------------------------------------------------------------------------
	// scoreboard: shadow registers, stress predictor and pending results
	// ------------------------------------------------------------------------
	class stress_scoreboard;
		logic [MOD_W-1:0]         lam, mu;
		logic [COEF_W-1:0]        biot, fric;
		logic signed [NORM_W-1:0] nrm[3];
		stress_set_t              pending[$];
		int                       errors;
		string                    names[7];

		function new();
			lam = '0; mu = '0; biot = '0; fric = COEF_W'(26214);
			nrm[0] = '0; nrm[1] = '0; nrm[2] = NORM_W'(65536);
			errors = 0;
			names = '{"stress_xx", "stress_yy", "stress_zz", "stress_xy",
				"stress_xz", "stress_yz", "failure_stress"};
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
			case (idx)
				REG_LAMBDA:   lam = d;
				REG_SHEAR:    mu = d;
				REG_BIOT:     biot = d[COEF_W-1:0];
				REG_FRICTION: fric = d[COEF_W-1:0];
				REG_NORMAL_X: nrm[0] = d[NORM_W-1:0];
				REG_NORMAL_Y: nrm[1] = d[NORM_W-1:0];
				REG_NORMAL_Z: nrm[2] = d[NORM_W-1:0];
				default: ;
			endcase
		endfunction

		function stress_t clamp42(logic signed [127:0] x);
			logic signed [127:0] hi, lo;
			hi = (128'sd1 <<< (OUT_W - 1)) - 1;
			lo = -(128'sd1 <<< (OUT_W - 1));
			if (x > hi) return hi[OUT_W-1:0];
			if (x < lo) return lo[OUT_W-1:0];
			return x[OUT_W-1:0];
		endfunction

		function stress_set_t hooke_cfs(cell_t c);
			stress_set_t r;
			logic signed [127:0] lam_w, mu2_w, biot_w, p_w, bp, half, esum, acc, ew;
			logic signed [127:0] tau2, tw[3], snw, root, cand;
			longint n[3], tq[3], t[3], sn, d;
			longint unsigned msn, fr, fw;
			int i;
			lam_w = 128'(lam);
			mu2_w = 128'(mu);
			mu2_w = mu2_w * 2;
			biot_w = 128'(biot);
			p_w = 128'(c.pres);
			bp = -((biot_w * p_w) <<< (FB - Q_FRAC));
			half = 128'sd1 <<< (FB - 1);
			esum = 0;
			for (i = 0; i < 3; i++) begin
				ew = 128'(c.e[i]);
				esum = esum + ew;
			end
			for (i = 0; i < 6; i++) begin
				ew = 128'(c.e[i]);
				acc = mu2_w * ew + half;
				if (i < 3) acc = acc + lam_w * esum + bp;
				r.v[i] = clamp42(acc >>> FB);
			end
			// traction and normal stress, 64-bit wrapping like the datapath
			for (i = 0; i < 3; i++) n[i] = 64'(nrm[i]);
			tq[0] = longint'(r.v[0]) * n[0] + longint'(r.v[3]) * n[1] + longint'(r.v[4]) * n[2];
			tq[1] = longint'(r.v[3]) * n[0] + longint'(r.v[1]) * n[1] + longint'(r.v[5]) * n[2];
			tq[2] = longint'(r.v[4]) * n[0] + longint'(r.v[5]) * n[1] + longint'(r.v[2]) * n[2];
			for (i = 0; i < 3; i++) t[i] = (tq[i] + ROUND16) >>> Q_FRAC;
			sn = (t[0] * n[0] + t[1] * n[1] + t[2] * n[2] + ROUND16) >>> Q_FRAC;
			// shear magnitude, floor root, zero for a negative argument
			for (i = 0; i < 3; i++) tw[i] = 128'(t[i]);
			snw = 128'(sn);
			tau2 = tw[0] * tw[0] + tw[1] * tw[1] + tw[2] * tw[2] - snw * snw;
			root = 0;
			if (tau2 > 0) begin
				for (i = 47; i >= 0; i--) begin
					cand = root | (128'sd1 <<< i);
					if (cand * cand <= tau2) root = cand;
				end
			end
			msn = (sn < 0) ? -sn : sn;
			fw = 64'(fric);
			fr = (fw * msn + 64'd32768) >> Q_FRAC;
			d = longint'(root[63:0]) - longint'(fr);
			r.v[6] = clamp42(128'(d));
			return r;
		endfunction

		function void note_cell(cell_t c);
			pending.push_back(hooke_cfs(c));
		endfunction

		function void check_result(stress_set_t got);
			stress_set_t want;
			if (pending.size() == 0) begin
				$error("result transaction with no cell outstanding");
				errors++;
				return;
			end
			want = pending.pop_front();
			for (int i = 0; i < 7; i++) begin
				if (got.v[i] !== want.v[i]) begin
					$error("%s expected %0d actual %0d", names[i], want.v[i], got.v[i]);
					errors++;
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid, in_stall, out_valid, out_stall;
	logic signed [STRAIN_W-1:0] strain_xx, strain_yy, strain_zz;
	logic signed [STRAIN_W-1:0] strain_xy, strain_xz, strain_yz;
	logic signed [PRES_W-1:0] pore_pressure;
	stress_t stress_xx, stress_yy, stress_zz, stress_xy, stress_xz, stress_yz;
	stress_t failure_stress;

	stress_scoreboard sb = new();
	// percent of cycles in which each side holds back
	int send_idle = 0;
	int recv_idle = 0;

	strain_to_coulomb_stress_core uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.strain_xx(strain_xx), .strain_yy(strain_yy), .strain_zz(strain_zz),
		.strain_xy(strain_xy), .strain_xz(strain_xz), .strain_yz(strain_yz),
		.pore_pressure(pore_pressure),
		.out_valid(out_valid), .out_stall(out_stall),
		.stress_xx(stress_xx), .stress_yy(stress_yy), .stress_zz(stress_zz),
		.stress_xy(stress_xy), .stress_xz(stress_xz), .stress_yz(stress_yz),
		.failure_stress(failure_stress)
	);

	// 4 ns clock
	always begin
		clk = 1'b0; #2;
		clk = 1'b1; #2;
	end

	// receiver: check each result transaction, then pick the next stall
	always @(posedge clk) begin
		stress_set_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.v = '{stress_xx, stress_yy, stress_zz, stress_xy, stress_xz,
				stress_yz, failure_stress};
			sb.check_result(got);
		end
		out_stall <= ($urandom_range(99) < recv_idle);
	end

	// register write, only while the core is idle
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, d);
	endtask

	// offer one cell, with random idle cycles first, until the core takes it
	task automatic send_cell(cell_t c);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		strain_xx <= c.e[0]; strain_yy <= c.e[1]; strain_zz <= c.e[2];
		strain_xy <= c.e[3]; strain_xz <= c.e[4]; strain_yz <= c.e[5];
		pore_pressure <= c.pres;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_cell(c);
	endtask

	// wait out every pending result plus the pipeline depth
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic cell_t fill_cell(logic signed [STRAIN_W-1:0] v,
		logic signed [PRES_W-1:0] p);
		cell_t c;
		for (int i = 0; i < 6; i++) c.e[i] = v;
		c.pres = p;
		return c;
	endfunction

	// half the cells use full-range fields, half realistic small strains
	function automatic cell_t random_cell();
		cell_t c;
		logic [20:0] s;
		logic [31:0] ph;
		if ($urandom_range(1)) begin
			for (int i = 0; i < 6; i++) c.e[i] = $urandom;
			ph = $urandom;
			c.pres = {ph[7:0], $urandom};
		end else begin
			for (int i = 0; i < 6; i++) begin
				s = 21'($urandom);
				c.e[i] = $signed(s);
			end
			ph = $urandom;
			c.pres = $signed(ph[27:0]);
		end
		return c;
	endfunction

	// one register setting per phase: realistic, full random or extreme
	task automatic load_setting(int phase);
		logic [CFG_W-1:0] v[7];
		logic [31:0] a, b;
		case (phase % 3)
			0: begin
				v[0] = CFG_W'($urandom_range(1 << 30)) * 64;
				v[1] = CFG_W'($urandom_range(1 << 30)) * 32;
				v[2] = CFG_W'($urandom_range(65536));
				v[3] = CFG_W'($urandom_range(65536));
				for (int i = 4; i < 7; i++) v[i] = 40'($signed(18'($urandom_range(131072) - 65536)));
			end
			1: begin
				for (int i = 0; i < 7; i++) begin
					a = $urandom; b = $urandom;
					v[i] = {a[7:0], b};
				end
			end
			default: begin
				if (phase == 5) begin
					for (int i = 0; i < 7; i++) v[i] = '0;
				end else begin
					v[0] = '1; v[1] = '1; v[2] = 40'h1ffff; v[3] = 40'h1ffff;
					// most negative normals on one pass, most positive on another
					for (int i = 4; i < 7; i++) v[i] = (phase == 8) ? 40'h20000 : 40'h1ffff;
				end
			end
		endcase
		write_reg(REG_LAMBDA, v[0]);
		write_reg(REG_SHEAR, v[1]);
		write_reg(REG_BIOT, v[2]);
		write_reg(REG_FRICTION, v[3]);
		write_reg(REG_NORMAL_X, v[4]);
		write_reg(REG_NORMAL_Y, v[5]);
		write_reg(REG_NORMAL_Z, v[6]);
		write_reg(REG_UNUSED, CFG_W'({$urandom, $urandom}));
	endtask

	initial begin
		cell_t c;
		arst_n = 1'b0;
		cfg_we <= 1'b0; cfg_index <= REG_LAMBDA; cfg_data <= '0;
		in_valid <= 1'b0;
		strain_xx <= '0; strain_yy <= '0; strain_zz <= '0;
		strain_xy <= '0; strain_xz <= '0; strain_yz <= '0;
		pore_pressure <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed cells, first under reset defaults, then a realistic rock
		for (int pass = 0; pass < 2; pass++) begin
			send_cell(fill_cell('0, '0));
			send_cell(fill_cell(32'sh7fffffff, 40'sh7fffffffff));
			send_cell(fill_cell(32'sh80000000, 40'sh8000000000));
			send_cell(fill_cell(32'sh7fffffff, 40'sh8000000000));
			send_cell(fill_cell(-32'sd1, 40'sd1));
			c = fill_cell('0, 40'sd1000000);
			c.e[0] = 32'sd1 <<< 20;
			send_cell(c);
			c = fill_cell('0, -40'sd5000);
			c.e[3] = -(32'sd1 <<< 22); c.e[5] = 32'sd3 <<< 18;
			send_cell(c);
			c = fill_cell('0, '0);
			c.e[2] = -(32'sd1 <<< 24); c.e[4] = 32'sd1 <<< 23;
			send_cell(c);
			drain();
			if (pass == 0) begin
				write_reg(REG_LAMBDA, 40'd30000000000);
				write_reg(REG_SHEAR, 40'd30000000000);
				write_reg(REG_BIOT, 40'd49152);
				write_reg(REG_FRICTION, 40'd39321);
				// plane not of unit length, used as written
				write_reg(REG_NORMAL_X, 40'd46341);
				write_reg(REG_NORMAL_Y, 40'd46341);
				write_reg(REG_NORMAL_Z, 40'd46341);
			end
		end

		// random phases: receiver-heavy idling, sender-heavy, then none
		for (int phase = 0; phase < 9; phase++) begin
			case (phase / 3)
				0: begin send_idle = 32; recv_idle = 75; end
				1: begin send_idle = 75; recv_idle = 32; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			load_setting(phase);
			repeat (100) send_cell(random_cell());
			drain();
		end

		if (sb.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#4ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
